FILE: hdl/veb_ci_pkg.sv
// Shared types, constants and helpers for the van Emde Boas child index block.
`timescale 1ns / 1ps

package veb_ci_pkg;

  localparam int MAX_HEIGHT = 32;
  localparam int HGT_W      = 6;
  localparam int IDX_W      = 32;
  localparam int SHF_W      = 5;   // holds a block height of up to 16
  localparam int BLK_W      = 16;  // bottom-tree size and quotient width

  // Start request for the block divider.
  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] dividend;
    logic [BLK_W-1:0] divisor;
    logic [SHF_W-1:0] steps;
  } div_req_t;

  // Completion status from the block divider.
  typedef struct packed {
    logic             done;
    logic [BLK_W-1:0] quotient;
  } div_rsp_t;

  // Largest power of two not above x, zero for zero.
  function automatic logic [HGT_W-1:0] hyper_floor(input logic [HGT_W-1:0] x);
    logic [HGT_W-1:0] p;
    p = '0;
    if (x[5])      p = 6'd32;
    else if (x[4]) p = 6'd16;
    else if (x[3]) p = 6'd8;
    else if (x[2]) p = 6'd4;
    else if (x[1]) p = 6'd2;
    else if (x[0]) p = 6'd1;
    return p;
  endfunction

endpackage

FILE: hdl/veb_ci_div.sv
// Restoring divider that finds which bottom block a position falls in, one bit per cycle.
`timescale 1ns / 1ps

module veb_ci_div
  import veb_ci_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r,  busy_nxt;
  logic             done_r,  done_nxt;
  logic [SHF_W-1:0] cnt_r,   cnt_nxt;
  logic [BLK_W-1:0] rem_r,   rem_nxt;
  logic [IDX_W-1:0] dsh_r,   dsh_nxt;
  logic [BLK_W-1:0] quo_r,   quo_nxt;
  logic [BLK_W-1:0] dvs_r,   dvs_nxt;

  logic [BLK_W:0]   trial;
  logic [BLK_W:0]   diff;
  logic [IDX_W-1:0] init_rem;
  logic [HGT_W-1:0] init_shift;

  // Quotient fits in steps bits, so the dividend's upper part starts as the remainder
  assign init_rem   = req.dividend >> req.steps;
  assign init_shift = HGT_W'(IDX_W) - HGT_W'(req.steps);
  assign trial      = {rem_r, dsh_r[IDX_W-1]};
  assign diff       = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      // load operands
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = init_rem[BLK_W-1:0];
      dsh_nxt  = req.dividend << init_shift;
      quo_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // one subtract-compare step
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[BLK_W-1:0];
        quo_nxt = {quo_r[BLK_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[BLK_W-1:0];
        quo_nxt = {quo_r[BLK_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r << 1;
      cnt_nxt = cnt_r - SHF_W'(1);
      if (cnt_r == SHF_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: hdl/veb_child_index_top.sv
// Top level: child position lookup in a van Emde Boas ordered complete binary tree.
// Sequence: an out-of-range word goes straight to S_FIN; otherwise each top-tree descent is a
//   pass through S_ROUND and each bottom-tree descent runs S_ROUND, S_DIV and S_UPD, with t,
//   that round's top height, as the bit-serial divider's step count.
// Throughput: one word at a time; a finished result waits in the output register while the
//   next word is taken. Synchronous active-low reset clears control, sets tree_height to 1.
`timescale 1ns / 1ps

module veb_child_index_top
  import veb_ci_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [HGT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_node_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_children_present,
  output logic [IDX_W-1:0] out_left_child,
  output logic [IDX_W-1:0] out_right_child,
  output logic             out_out_of_range
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_DIV   = 5'b00100,
    S_UPD   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t           state_r,   state_nxt;
  logic [HGT_W-1:0] height_r,  height_nxt;
  logic [HGT_W-1:0] h_r,       h_nxt;
  logic [IDX_W-1:0] node_r,    node_nxt;
  logic [IDX_W-1:0] start_r,   start_nxt;
  logic [IDX_W-1:0] src_r,     src_nxt;
  logic [SHF_W-1:0] sb_r,      sb_nxt;
  logic [SHF_W-1:0] b_r,       b_nxt;
  logic             pres_r,    pres_nxt;
  logic             oor_r,     oor_nxt;
  logic             ov_r,      ov_nxt;
  logic             ocp_r,     ocp_nxt;
  logic [IDX_W-1:0] olc_r,     olc_nxt;
  logic [IDX_W-1:0] orc_r,     orc_nxt;
  logic             oor_out_r, oor_out_nxt;

  logic [HGT_W-1:0] h_sat;
  logic [IDX_W:0]   tree_size;
  logic [HGT_W-1:0] b_c;
  logic [HGT_W-1:0] t_c;
  logic [IDX_W-1:0] ntop_c;
  logic [IDX_W-1:0] nbot_c;
  logic [IDX_W:0]   top_end;
  logic [IDX_W-1:0] start_top;
  logic [IDX_W-1:0] blk_w;
  logic [IDX_W-1:0] stride_c;
  logic [IDX_W-1:0] blk_bot;
  logic [IDX_W-1:0] blk_src;
  logic             out_free;
  div_req_t         dreq;
  div_rsp_t         drsp;

  veb_ci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Saturate height and size the tree
  assign h_sat     = (height_r > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : height_r;
  assign tree_size = ((IDX_W+1)'(1) << h_sat) - (IDX_W+1)'(1);

  // Split the current subtree into top and bottom parts
  assign b_c       = hyper_floor(h_r - HGT_W'(1));
  assign t_c       = h_r - b_c;
  assign ntop_c    = (IDX_W'(1) << t_c) - IDX_W'(1);
  assign nbot_c    = (IDX_W'(1) << b_c) - IDX_W'(1);
  assign top_end   = {1'b0, start_r} + {1'b0, ntop_c};
  assign start_top = start_r + ntop_c;

  // Block offsets: multiply by 2^k - 1 as shift and subtract
  assign blk_w    = {{(IDX_W-BLK_W){1'b0}}, drsp.quotient};
  assign blk_bot  = (blk_w << b_r) - blk_w;
  assign stride_c = (IDX_W'(1) << sb_r) - IDX_W'(1);
  assign blk_src  = ((blk_w << sb_r) - blk_w) << b_r;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    height_nxt  = height_r;
    h_nxt       = h_r;
    node_nxt    = node_r;
    start_nxt   = start_r;
    src_nxt     = src_r;
    sb_nxt      = sb_r;
    b_nxt       = b_r;
    pres_nxt    = pres_r;
    oor_nxt     = oor_r;
    ov_nxt      = ov_r;
    ocp_nxt     = ocp_r;
    olc_nxt     = olc_r;
    orc_nxt     = orc_r;
    oor_out_nxt = oor_out_r;
    dreq.start    = 1'b0;
    dreq.dividend = node_r - start_top;
    dreq.divisor  = nbot_c[BLK_W-1:0];
    dreq.steps    = t_c[SHF_W-1:0];

    if (cfg_we) begin
      height_nxt = cfg_wdata;
    end
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // take a word, flag it at once when outside the tree
        if (in_valid) begin
          node_nxt  = in_node_index;
          h_nxt     = h_sat;
          start_nxt = '0;
          src_nxt   = '0;
          sb_nxt    = '0;
          pres_nxt  = 1'b0;
          oor_nxt   = (h_sat == '0) || ({1'b0, in_node_index} >= tree_size);
          state_nxt = oor_nxt ? S_FIN : S_ROUND;
        end
      end
      S_ROUND: begin
        // descend into the top tree, or start the bottom block search
        if (h_r <= HGT_W'(1)) begin
          state_nxt = S_FIN;
        end else if ({1'b0, node_r} < top_end) begin
          h_nxt    = t_c;
          pres_nxt = 1'b1;
          src_nxt  = start_top;
          sb_nxt   = b_c[SHF_W-1:0];
        end else begin
          start_nxt  = start_top;
          b_nxt      = b_c[SHF_W-1:0];
          dreq.start = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // advance to the chosen bottom block
        start_nxt = start_r + blk_bot;
        src_nxt   = src_r + blk_src;
        h_nxt     = HGT_W'(b_r);
        state_nxt = S_ROUND;
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          ov_nxt      = 1'b1;
          ocp_nxt     = pres_r && !oor_r;
          olc_nxt     = (pres_r && !oor_r) ? src_r : '0;
          orc_nxt     = (pres_r && !oor_r) ? (src_r + stride_c) : '0;
          oor_out_nxt = oor_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      height_r <= HGT_W'(1);
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      height_r <= height_nxt;
      ov_r     <= ov_nxt;
    end
    h_r       <= h_nxt;
    node_r    <= node_nxt;
    start_r   <= start_nxt;
    src_r     <= src_nxt;
    sb_r      <= sb_nxt;
    b_r       <= b_nxt;
    pres_r    <= pres_nxt;
    oor_r     <= oor_nxt;
    ocp_r     <= ocp_nxt;
    olc_r     <= olc_nxt;
    orc_r     <= orc_nxt;
    oor_out_r <= oor_out_nxt;
  end

  assign out_valid            = ov_r;
  assign out_children_present = ocp_r;
  assign out_left_child       = olc_r;
  assign out_right_child      = orc_r;
  assign out_out_of_range     = oor_out_r;

  // An out-of-range word never reports children
  a_oor_no_child: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oor_out_r |-> !ocp_r && olc_r == '0 && orc_r == '0)
    else $error("out-of-range result carries children");

  // A leaf result gives zero positions
  a_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ocp_r |-> olc_r == '0 && orc_r == '0)
    else $error("leaf result has nonzero child positions");

  // The divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_DIV)
    else $error("divider done outside the divide state");

  // A division starts only from a subtree taller than one level
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && state_nxt == S_DIV |-> h_r > HGT_W'(1))
    else $error("division started on a single-level subtree");

endmodule

FILE: tb/tb_veb_child_index_top.sv
// Testbench for veb_child_index_top: random and directed child lookups checked against a predictor.
`timescale 1ns / 1ps

module tb_veb_child_index_top;
  import veb_ci_pkg::*;

  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 60;
  localparam int MAX_REPORTS      = 10;

  // One expected lookup result, with the request it belongs to.
  typedef struct {
    logic [IDX_W-1:0] node;
    logic [HGT_W-1:0] levels;
    logic             present;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             oor;
  } child_pos_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [HGT_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [IDX_W-1:0] in_node_index = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_children_present;
  logic [IDX_W-1:0] out_left_child;
  logic [IDX_W-1:0] out_right_child;
  logic             out_out_of_range;

  logic [IDX_W-1:0] pending_nodes[$];
  child_pos_t       expected_children[$];
  logic [HGT_W-1:0] tree_levels = 6'd1;
  logic             node_taken = 1'b0;
  logic             steady = 1'b0;
  logic             long_hold_done = 1'b0;
  int               send_gap = 0;
  int               hold_off = 0;
  int               quiet_cycles = 0;
  int               words_queued = 0;
  int               words_accepted = 0;
  int               results_checked = 0;
  int               leaf_results = 0;
  int               oor_results = 0;
  int               heights_used = 1;
  int               errors = 0;

  veb_child_index_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_node_index       (in_node_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_children_present(out_children_present),
    .out_left_child      (out_left_child),
    .out_right_child     (out_right_child),
    .out_out_of_range    (out_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Descend through top and bottom trees of the van Emde Boas layout to find the children.
  function automatic child_pos_t find_children(input logic [IDX_W-1:0] node_idx,
                                               input logic [HGT_W-1:0] levels);
    longint unsigned node, h, base, first_child, step, bot_h, top_h, top_cnt, bot_cnt, blk;
    child_pos_t      res;
    node        = 64'(node_idx);
    h           = (levels > HGT_W'(MAX_HEIGHT)) ? 64'(MAX_HEIGHT) : 64'(levels);
    base        = 0;
    first_child = 0;
    step        = 0;
    res.node    = node_idx;
    res.levels  = levels;
    res.present = 1'b0;
    res.left    = '0;
    res.right   = '0;
    res.oor     = 1'b0;
    if (h == 0 || node >= ((64'd1 << h) - 1)) begin
      res.oor = 1'b1;
      return res;
    end
    while (h > 1) begin
      // bottom height is the largest power of two not above h - 1
      bot_h = 1;
      while ((bot_h << 1) <= h - 1) bot_h = bot_h << 1;
      top_h   = h - bot_h;
      top_cnt = (64'd1 << top_h) - 1;
      bot_cnt = (64'd1 << bot_h) - 1;
      if (node < base + top_cnt) begin
        h           = top_h;
        res.present = 1'b1;
        first_child = base + top_cnt;
        step        = bot_cnt;
      end else begin
        base        = base + top_cnt;
        blk         = (node - base) / bot_cnt;
        h           = bot_h;
        base        = base + bot_cnt * blk;
        first_child = first_child + step * (64'd1 << bot_h) * blk;
      end
    end
    if (res.present) begin
      res.left  = first_child[IDX_W-1:0];
      res.right = IDX_W'(first_child + step);
    end
    return res;
  endfunction

  // Short gaps mostly, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // Mostly nodes inside the tree, some boundaries, some beyond the last node.
  function automatic logic [IDX_W-1:0] pick_node(input logic [HGT_W-1:0] levels);
    longint unsigned span;
    int unsigned     eff, r;
    eff  = (levels > HGT_W'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(levels);
    span = (64'd1 << eff) - 1;
    r    = $urandom_range(0, 99);
    if (span == 0 || r >= 90) begin
      if (span >= 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return $urandom_range(32'(span), 32'hFFFF_FFFF);
    end
    if (r >= 84) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return 32'(span - 1);
        default: return 32'(span);
      endcase
    end
    return $urandom_range(0, 32'(span - 1));
  endfunction

  // Present words from the queue; hold each until taken, then sometimes idle a while.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !node_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_nodes.size() != 0) begin
      in_valid      <= 1'b1;
      in_node_index <= pending_nodes.pop_front();
      send_gap      <= (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Stall the result side at random; once, hold off long enough to back up the input.
  always @(negedge clk) begin
    if (hold_off != 0) begin
      out_ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else if (!long_hold_done && words_accepted >= LONG_HOLD_AT &&
                 pending_nodes.size() > 10) begin
      out_ready      <= 1'b0;
      hold_off       <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_off  <= pick_gap();
    end
  end

  // Check results, predict accepted words, track the height register, watch for a hang.
  always @(posedge clk) begin : monitor
    child_pos_t want;
    if (!rst_n) begin
      node_taken  <= 1'b0;
      tree_levels = 6'd1;
    end else begin
      node_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_children.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("unexpected result: present=%0b left=%h right=%h oor=%0b",
                     out_children_present, out_left_child, out_right_child,
                     out_out_of_range);
          errors++;
        end else begin
          want = expected_children.pop_front();
          results_checked++;
          if (want.oor) oor_results++;
          else if (!want.present) leaf_results++;
          if (out_children_present !== want.present || out_left_child !== want.left ||
              out_right_child !== want.right || out_out_of_range !== want.oor) begin
            if (errors < MAX_REPORTS) begin
              $display("mismatch node %h height %0d:", want.node, want.levels);
              $display("  expected present=%0b left=%h right=%h oor=%0b",
                       want.present, want.left, want.right, want.oor);
              $display("  got present=%0b left=%h right=%h oor=%0b", out_children_present,
                       out_left_child, out_right_child, out_out_of_range);
            end
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_children.push_back(find_children(in_node_index, tree_levels));
        words_accepted++;
      end
      if (cfg_we) tree_levels = cfg_wdata;
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d words still expected", expected_children.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Wait for every queued word to be taken and every result to come back.
  task automatic wait_idle();
    while (words_accepted != words_queued || expected_children.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write the height register while the block is idle.
  task automatic set_height(input logic [HGT_W-1:0] levels);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= levels;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    heights_used++;
  endtask

  task automatic queue_node(input logic [IDX_W-1:0] node);
    pending_nodes.push_back(node);
    words_queued++;
  endtask

  initial begin : stimulus
    logic [HGT_W-1:0] phase_heights[14];
    phase_heights = '{6'd5, 6'd32, 6'd17, 6'd4, 6'd12, 6'd63, 6'd9, 6'd1,
                      6'd33, 6'd2, 6'd24, 6'd0, 6'd31, 6'd0};
    phase_heights[13] = HGT_W'($urandom_range(0, 63));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset height of one, a root-only tree
    queue_node(32'd0);
    queue_node(32'd1);
    queue_node(32'hFFFF_FFFF);
    // empty tree
    set_height(6'd0);
    queue_node(32'd0);
    queue_node(32'hFFFF_FFFF);
    // three nodes: root, two leaves, first index outside
    set_height(6'd2);
    queue_node(32'd0);
    queue_node(32'd1);
    queue_node(32'd2);
    queue_node(32'd3);
    // root over two bottom trees
    set_height(6'd3);
    queue_node(32'd0);
    queue_node(32'd4);
    queue_node(32'd6);
    queue_node(32'd7);
    // largest tree, and a height above the maximum that saturates to it
    set_height(6'd32);
    queue_node(32'd0);
    queue_node(32'd1);
    queue_node(32'h7FFF_FFFF);
    queue_node(32'hFFFF_FFFE);
    queue_node(32'hFFFF_FFFF);
    set_height(6'd63);
    queue_node(32'd0);
    queue_node(32'hFFFF_FFFE);
    queue_node(32'hFFFF_FFFF);

    // random phases, one height each; every fourth phase runs without idling
    for (int p = 0; p < 14; p++) begin
      set_height(phase_heights[p]);
      steady = (p % 4 == 3);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_node(pick_node(phase_heights[p]));
    end

    wait_idle();
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_children.size() != 0) begin
      $display("%0d results never arrived", expected_children.size());
      errors += expected_children.size();
    end
    $display("checked %0d lookups over %0d height settings", results_checked, heights_used);
    $display("  of them %0d leaves and %0d outside the tree", leaf_results, oor_results);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
